/* rtl/bedm_pkg.sv */
// ----------------------------------------------------------------------------
// bedm_pkg: shared types and constants for the edge-sensing demosaic
// Payload structs for each pipeline stage, register indexes and reset values.
// ----------------------------------------------------------------------------
package bedm_pkg;

	localparam int MAX_DIM_DEFAULT = 4096;

	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 13;

	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_GREEN_PHASE  = 2'd2;

	localparam logic [12:0] IMAGE_WIDTH_RESET  = 13'd640;
	localparam logic [12:0] IMAGE_HEIGHT_RESET = 13'd480;
	localparam logic        GREEN_PHASE_RESET  = 1'b1;

	// floor(s/3) == (s*683)>>11 for every s up to 1020
	localparam logic [9:0] DIV3_MUL   = 10'd683;
	localparam int         DIV3_SHIFT = 11;

	typedef struct packed {
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [7:0]  center_pixel;
		logic [7:0]  north_pixel;
		logic [7:0]  south_pixel;
		logic [7:0]  west_pixel;
		logic [7:0]  east_pixel;
		logic [7:0]  northwest_pixel;
		logic [7:0]  northeast_pixel;
		logic [7:0]  southwest_pixel;
		logic [7:0]  southeast_pixel;
	} bedm_pixel_t;

	// neighborhood with absent neighbors already forced to zero
	typedef struct packed {
		logic [7:0] c;
		logic [7:0] n;
		logic [7:0] s;
		logic [7:0] w;
		logic [7:0] e;
		logic [7:0] nw;
		logic [7:0] ne;
		logic [7:0] sw;
		logic [7:0] se;
		logic       has_n;
		logic       has_s;
		logic       has_w;
		logic       has_e;
		logic       is_green;
		logic       even_row;
	} bedm_nbhd_t;

	typedef struct packed {
		logic [9:0] sum;
		logic [2:0] cnt;
	} bedm_acc_t;

	typedef struct packed {
		bedm_acc_t red;
		bedm_acc_t green;
		bedm_acc_t blue;
	} bedm_acc3_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
	} bedm_rgb_t;

endpackage

/* rtl/bedm_if.sv */
// ----------------------------------------------------------------------------
// bedm_if: stream channels of the demosaic
// Raw pixel neighborhood in, reconstructed RGB out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bedm_pixel_if;
	logic        valid;
	logic        ready;
	logic [11:0] pos_x;
	logic [11:0] pos_y;
	logic [7:0]  center_pixel;
	logic [7:0]  north_pixel;
	logic [7:0]  south_pixel;
	logic [7:0]  west_pixel;
	logic [7:0]  east_pixel;
	logic [7:0]  northwest_pixel;
	logic [7:0]  northeast_pixel;
	logic [7:0]  southwest_pixel;
	logic [7:0]  southeast_pixel;

	modport source (
		output valid, pos_x, pos_y, center_pixel, north_pixel, south_pixel,
			west_pixel, east_pixel, northwest_pixel, northeast_pixel,
			southwest_pixel, southeast_pixel,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, center_pixel, north_pixel, south_pixel,
			west_pixel, east_pixel, northwest_pixel, northeast_pixel,
			southwest_pixel, southeast_pixel,
		output ready
	);
endinterface

interface bedm_rgb_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;

	modport source (output valid, red_out, green_out, blue_out, input ready);
	modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

/* rtl/bayer_edge_sensing_demosaic_core.sv */
// ----------------------------------------------------------------------------
// bayer_edge_sensing_demosaic_core: edge-sensing Bayer demosaic
// Three-stage pipeline: border masking, edge decision and sums, normalize.
// ----------------------------------------------------------------------------
// Each accepted pixel passes the border, interp and norm stage registers to rgb.
// Throughput: one pixel per cycle unless rgb stalls; each of the three stage
// registers holds one pixel and advances as soon as the stage after it has room.
// Reset: arst_n clears all stage valid bits and returns image_width to 640,
// image_height to 480 and green_phase to 1.
module bayer_edge_sensing_demosaic_core #(
	parameter int MAX_DIM = bedm_pkg::MAX_DIM_DEFAULT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	bedm_pixel_if.sink                           pix,
	bedm_rgb_if.source                           rgb,
	input  logic                                 cfg_we,
	input  logic [bedm_pkg::CFG_IDX_BITS-1:0]    cfg_idx,
	input  logic [bedm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);

	logic [12:0] image_width_q;
	logic [12:0] image_height_q;
	logic        green_phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= bedm_pkg::IMAGE_WIDTH_RESET;
			image_height_q <= bedm_pkg::IMAGE_HEIGHT_RESET;
			green_phase_q  <= bedm_pkg::GREEN_PHASE_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				bedm_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[12:0];
				bedm_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata[12:0];
				bedm_pkg::CFG_GREEN_PHASE:  green_phase_q  <= cfg_wdata[0];
				default: ; // drop writes to unmapped indexes
			endcase
		end
	end

	bedm_pkg::bedm_pixel_t pix_data;
	bedm_pkg::bedm_nbhd_t  nbhd_s1;
	bedm_pkg::bedm_acc3_t  acc_s2;
	bedm_pkg::bedm_rgb_t   rgb_s3;
	logic                  v_s1, v_s2;
	logic                  rdy_s2, rdy_s3;

	assign pix_data = '{
		pos_x:           pix.pos_x,
		pos_y:           pix.pos_y,
		center_pixel:    pix.center_pixel,
		north_pixel:     pix.north_pixel,
		south_pixel:     pix.south_pixel,
		west_pixel:      pix.west_pixel,
		east_pixel:      pix.east_pixel,
		northwest_pixel: pix.northwest_pixel,
		northeast_pixel: pix.northeast_pixel,
		southwest_pixel: pix.southwest_pixel,
		southeast_pixel: pix.southeast_pixel
	};

	bedm_border_stage #(.MAX_DIM(MAX_DIM)) u_border (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (pix.valid),
		.in_ready     (pix.ready),
		.in_data      (pix_data),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.green_phase  (green_phase_q),
		.out_valid    (v_s1),
		.out_ready    (rdy_s2),
		.out_data     (nbhd_s1)
	);

	bedm_interp_stage u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (rdy_s2),
		.in_data   (nbhd_s1),
		.out_valid (v_s2),
		.out_ready (rdy_s3),
		.out_data  (acc_s2)
	);

	bedm_norm_stage u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s2),
		.in_ready  (rdy_s3),
		.in_data   (acc_s2),
		.out_valid (rgb.valid),
		.out_ready (rgb.ready),
		.out_data  (rgb_s3)
	);

	assign rgb.red_out   = rgb_s3.red_out;
	assign rgb.green_out = rgb_s3.green_out;
	assign rgb.blue_out  = rgb_s3.blue_out;

	// input backpressure only when every stage is full and the output stalls
	a_full_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!pix.ready |-> (v_s1 && v_s2 && rgb.valid && !rgb.ready))
		else $error("input stalled with room in the pipeline");

	// neighbor counts never exceed four
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (acc_s2.red.cnt <= 3'd4 && acc_s2.green.cnt <= 3'd4
			&& acc_s2.blue.cnt <= 3'd4))
		else $error("neighbor count out of range");

	// a green site passes its own value through untouched
	a_green_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && rdy_s2 && nbhd_s1.is_green) |=>
			(acc_s2.green.cnt == 3'd1 && acc_s2.green.sum == 10'($past(nbhd_s1.c))))
		else $error("green site lost its center value");

endmodule

/* rtl/bedm_border_stage.sv */
// ----------------------------------------------------------------------------
// bedm_border_stage: first pipeline stage
// Border tests against the clamped image size, neighbor masking, site class.
// ----------------------------------------------------------------------------
module bedm_border_stage #(
	parameter int MAX_DIM = bedm_pkg::MAX_DIM_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bedm_pkg::bedm_pixel_t in_data,
	input  logic [12:0]          image_width,
	input  logic [12:0]          image_height,
	input  logic                 green_phase,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bedm_pkg::bedm_nbhd_t out_data
);

	localparam int DimW = $clog2(MAX_DIM + 1);
	localparam int CmpW = (DimW > 13) ? DimW : 13;

	logic [CmpW-1:0]      w_clamp;
	logic [CmpW-1:0]      h_clamp;
	logic [CmpW-1:0]      x_ext;
	logic [CmpW-1:0]      y_ext;
	logic                 has_n, has_s, has_w, has_e;
	bedm_pkg::bedm_nbhd_t nbhd;
	logic                 valid_s1;
	bedm_pkg::bedm_nbhd_t data_s1;

	always_comb begin
		w_clamp = (CmpW'(image_width) > CmpW'(MAX_DIM)) ? CmpW'(MAX_DIM) : CmpW'(image_width);
		h_clamp = (CmpW'(image_height) > CmpW'(MAX_DIM)) ? CmpW'(MAX_DIM) : CmpW'(image_height);
		x_ext   = CmpW'(in_data.pos_x);
		y_ext   = CmpW'(in_data.pos_y);
		has_n   = (in_data.pos_y != 12'd0);
		has_w   = (in_data.pos_x != 12'd0);
		has_s   = (y_ext + CmpW'(1)) < h_clamp;
		has_e   = (x_ext + CmpW'(1)) < w_clamp;

		nbhd.c        = in_data.center_pixel;
		nbhd.n        = has_n ? in_data.north_pixel : 8'd0;
		nbhd.s        = has_s ? in_data.south_pixel : 8'd0;
		nbhd.w        = has_w ? in_data.west_pixel  : 8'd0;
		nbhd.e        = has_e ? in_data.east_pixel  : 8'd0;
		nbhd.nw       = (has_n && has_w) ? in_data.northwest_pixel : 8'd0;
		nbhd.ne       = (has_n && has_e) ? in_data.northeast_pixel : 8'd0;
		nbhd.sw       = (has_s && has_w) ? in_data.southwest_pixel : 8'd0;
		nbhd.se       = (has_s && has_e) ? in_data.southeast_pixel : 8'd0;
		nbhd.has_n    = has_n;
		nbhd.has_s    = has_s;
		nbhd.has_w    = has_w;
		nbhd.has_e    = has_e;
		nbhd.is_green = (in_data.pos_x[0] ^ in_data.pos_y[0]) == green_phase;
		nbhd.even_row = ~in_data.pos_y[0];
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= nbhd;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

/* rtl/bedm_interp_stage.sv */
// ----------------------------------------------------------------------------
// bedm_interp_stage: second pipeline stage
// Neighbor sums and counts, edge-direction decision for green, color routing.
// ----------------------------------------------------------------------------
module bedm_interp_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bedm_pkg::bedm_nbhd_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bedm_pkg::bedm_acc3_t out_data
);

	logic [8:0]           hsum, vsum;
	logic [9:0]           asum, dsum;
	logic [2:0]           hcnt, vcnt, acnt, dcnt;
	logic [7:0]           dh, dv, thr;
	logic [8:0]           dsum_hv;
	bedm_pkg::bedm_acc_t  hacc, vacc, aacc, dacc, cacc;
	bedm_pkg::bedm_acc3_t acc;
	logic                 valid_s2;
	bedm_pkg::bedm_acc3_t data_s2;

	always_comb begin
		hsum = {1'b0, in_data.w} + {1'b0, in_data.e};
		vsum = {1'b0, in_data.n} + {1'b0, in_data.s};
		asum = {1'b0, hsum} + {1'b0, vsum};
		dsum = 10'(in_data.nw) + 10'(in_data.ne) + 10'(in_data.sw) + 10'(in_data.se);

		hcnt = 3'(in_data.has_w) + 3'(in_data.has_e);
		vcnt = 3'(in_data.has_n) + 3'(in_data.has_s);
		acnt = hcnt + vcnt;
		dcnt = 3'(in_data.has_n && in_data.has_w) + 3'(in_data.has_n && in_data.has_e)
			+ 3'(in_data.has_s && in_data.has_w) + 3'(in_data.has_s && in_data.has_e);

		dh      = (in_data.e > in_data.w) ? in_data.e - in_data.w : in_data.w - in_data.e;
		dv      = (in_data.n > in_data.s) ? in_data.n - in_data.s : in_data.s - in_data.n;
		dsum_hv = {1'b0, dh} + {1'b0, dv};
		thr     = dsum_hv[8:1];

		hacc = '{sum: {1'b0, hsum}, cnt: hcnt};
		vacc = '{sum: {1'b0, vsum}, cnt: vcnt};
		aacc = '{sum: asum, cnt: acnt};
		dacc = '{sum: dsum, cnt: dcnt};
		cacc = '{sum: 10'(in_data.c), cnt: 3'd1};

		if (in_data.is_green) begin
			acc.green = cacc;
			acc.red   = in_data.even_row ? hacc : vacc;
			acc.blue  = in_data.even_row ? vacc : hacc;
		end else begin
			// strong vertical gradient: interpolate along the row, and vice versa
			if (dh < thr && dv > thr) begin
				acc.green = hacc;
			end else if (dh > thr && dv < thr) begin
				acc.green = vacc;
			end else begin
				acc.green = aacc;
			end
			acc.red  = in_data.even_row ? cacc : dacc;
			acc.blue = in_data.even_row ? dacc : cacc;
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s2 <= acc;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

/* rtl/bedm_norm_stage.sv */
// ----------------------------------------------------------------------------
// bedm_norm_stage: third pipeline stage and output register
// Divides each color sum by its neighbor count (0 to 4), truncating; a zero count gives 0.
// ----------------------------------------------------------------------------
module bedm_norm_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  bedm_pkg::bedm_acc3_t in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output bedm_pkg::bedm_rgb_t  out_data
);

	function automatic logic [7:0] avg(input bedm_pkg::bedm_acc_t a);
		logic [19:0] prod;
		logic [7:0]  q;
		prod = 20'(a.sum) * 20'(bedm_pkg::DIV3_MUL);
		case (a.cnt)
			3'd1:    q = a.sum[7:0];
			3'd2:    q = a.sum[8:1];
			3'd3:    q = prod[bedm_pkg::DIV3_SHIFT +: 8];
			3'd4:    q = a.sum[9:2];
			default: q = 8'd0; // no neighbor present
		endcase
		return q;
	endfunction

	bedm_pkg::bedm_rgb_t rgb;
	logic                valid_s3;
	bedm_pkg::bedm_rgb_t data_s3;

	always_comb begin
		rgb.red_out   = avg(in_data.red);
		rgb.green_out = avg(in_data.green);
		rgb.blue_out  = avg(in_data.blue);
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s3 <= rgb;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule
